// ===== hw/rtl/button_click_classifier_assert.svh =====
// Assertion macros shared by the button click classifier modules.
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define BCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define BCC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/bcc_pkg.sv =====
// Types and constants of the button click classifier.
package bcc_pkg;

    localparam int unsigned CntW  = 12;
    localparam int unsigned IdxW  = 3;
    localparam int unsigned ByteW = 8;

    // Configuration register indexes.
    localparam logic [IdxW-1:0] RegEdgeEnable  = 3'd0;
    localparam logic [IdxW-1:0] RegLongPress   = 3'd1;
    localparam logic [IdxW-1:0] RegMinPress    = 3'd2;
    localparam logic [IdxW-1:0] RegDoubleGapLo = 3'd3;
    localparam logic [IdxW-1:0] RegClickWindow = 3'd4;

    // Reset values of the configuration registers.
    localparam logic            RstEdgeEnable  = 1'b1;
    localparam logic [CntW-1:0] RstLongPress   = 12'd1100;
    localparam logic [CntW-1:0] RstMinPress    = 12'd50;
    localparam logic [CntW-1:0] RstDoubleGapLo = 12'd50;
    localparam logic [CntW-1:0] RstClickWindow = 12'd300;

    typedef struct packed {
        logic            edge_enable;
        logic [CntW-1:0] long_press_ticks;
        logic [CntW-1:0] min_press_ticks;
        logic [CntW-1:0] double_gap_low;
        logic [CntW-1:0] click_window_ticks;
    } t_cfg;

    typedef struct packed {
        logic double_click;
        logic long_press;
        logic short_click;
    } t_result;

endpackage

// ===== hw/rtl/bcc_cfg.sv =====
// Configuration register file of the button click classifier.
module bcc_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [bcc_pkg::IdxW-1:0] i_cfg_index,
    input  logic [bcc_pkg::CntW-1:0] i_cfg_data,
    output bcc_pkg::t_cfg            o_cfg
);

    bcc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_enable        <= bcc_pkg::RstEdgeEnable;
            r_cfg.long_press_ticks   <= bcc_pkg::RstLongPress;
            r_cfg.min_press_ticks    <= bcc_pkg::RstMinPress;
            r_cfg.double_gap_low     <= bcc_pkg::RstDoubleGapLo;
            r_cfg.click_window_ticks <= bcc_pkg::RstClickWindow;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bcc_pkg::RegEdgeEnable:  r_cfg.edge_enable        <= i_cfg_data[0];
                bcc_pkg::RegLongPress:   r_cfg.long_press_ticks   <= i_cfg_data;
                bcc_pkg::RegMinPress:    r_cfg.min_press_ticks    <= i_cfg_data;
                bcc_pkg::RegDoubleGapLo: r_cfg.double_gap_low     <= i_cfg_data;
                bcc_pkg::RegClickWindow: r_cfg.click_window_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/bcc_core.sv =====
// Classifier state and the per-tick next-state and result logic.
`include "button_click_classifier_assert.svh"

module bcc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_key_pressed,
    input  logic               i_press_edge,
    input  bcc_pkg::t_cfg      i_cfg,
    output bcc_pkg::t_result   o_result
);

    logic                     r_armed;
    logic [bcc_pkg::CntW-1:0] r_hold;
    logic                     r_release;
    logic [bcc_pkg::CntW-1:0] r_gap;

    logic                     n_armed;
    logic [bcc_pkg::CntW-1:0] n_hold;
    logic                     n_release;
    logic [bcc_pkg::CntW-1:0] n_gap;

    logic                     rel_set;
    logic [bcc_pkg::CntW-1:0] gap_mid;
    logic [bcc_pkg::CntW:0]   gap_inc;
    bcc_pkg::t_result         res;

    always_comb begin
        n_armed  = r_armed | (i_press_edge & i_cfg.edge_enable);
        n_hold   = r_hold;
        rel_set  = r_release;
        gap_mid  = r_gap;
        res      = '0;

        // Hold phase, on the state as armed by this tick's edge.
        if (n_armed) begin
            if (i_key_pressed) begin
                if (r_hold < i_cfg.long_press_ticks) begin
                    n_hold = r_hold + 1'b1;
                end else begin
                    n_hold         = '0;
                    n_armed        = 1'b0;
                    res.long_press = 1'b1;
                end
            end else begin
                n_hold  = '0;
                n_armed = 1'b0;
                if (r_hold > i_cfg.min_press_ticks) begin
                    if ((r_gap > i_cfg.double_gap_low) &&
                        (r_gap < i_cfg.click_window_ticks)) begin
                        res.double_click = 1'b1;
                        rel_set          = 1'b0;
                        gap_mid          = '0;
                    end else begin
                        rel_set = 1'b1;
                    end
                end
            end
        end

        // Gap phase: compare one bit wider so a full-scale window still ends.
        gap_inc   = {1'b0, gap_mid} + {{bcc_pkg::CntW{1'b0}}, rel_set};
        n_release = rel_set;
        n_gap     = gap_inc[bcc_pkg::CntW-1:0];
        if (gap_inc > {1'b0, i_cfg.click_window_ticks}) begin
            res.short_click = 1'b1;
            n_gap           = '0;
            n_release       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_hold    <= '0;
            r_release <= 1'b0;
            r_gap     <= '0;
        end else if (i_step) begin
            r_armed   <= n_armed;
            r_hold    <= n_hold;
            r_release <= n_release;
            r_gap     <= n_gap;
        end
    end

    assign o_result = res;

    // A long press and a window end may land on the same tick; a double click never
    // coincides with a short click since it clears the gap.
    `BCC_ASSERT_NOW(a_double_not_short, i_clk, i_rst_n, i_step, !(res.double_click && res.short_click))
    `BCC_ASSERT_NOW(a_idle_hold_clear, i_clk, i_rst_n, !r_armed, r_hold == '0)
    `BCC_ASSERT_NOW(a_idle_gap_clear, i_clk, i_rst_n, !r_release, r_gap == '0)

endmodule

// ===== hw/rtl/button_click_classifier.sv =====
// Top level of the button click classifier.
//
// Usage: feed one transaction per millisecond tick on the s_axis channel.
//   s_axis_tdata[0] = key_pressed (1 = pressed), s_axis_tdata[1] = press_edge.
// Every input transaction yields exactly one output transaction on m_axis:
//   m_axis_tdata[0] = short_click, [1] = long_press, [2] = double_click,
//   each a one-tick pulse, all zero on most ticks.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_wr_en is
//   high (0 edge_enable, 1 long_press_ticks, 2 min_press_ticks,
//   3 double_gap_low, 4 click_window_ticks). Write only while the stream is idle.
// Pipeline: an accepted input passes the input register, then the result register;
//   the tick logic sits between those two registers.
// Throughput: one transaction per cycle while m_axis_tready stays high; each accepted
//   transaction steps the registered classifier state once.
// Reset (synchronous, active low) clears both pipeline registers and the
//   classifier state and reloads the default register values.
// Stall: when m_axis_tready is low the result register holds and the input
//   register still takes one more transaction; then s_axis_tready drops.
`include "button_click_classifier_assert.svh"

module button_click_classifier (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Slave stream: tdata bits from low: key_pressed, press_edge; upper bits unused.
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [bcc_pkg::ByteW-1:0] s_axis_tdata,
    // Master stream: tdata bits from low: short_click, long_press, double_click, zero pad.
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [bcc_pkg::ByteW-1:0] m_axis_tdata,
    // Configuration write port.
    input  logic                      i_cfg_wr_en,
    input  logic [bcc_pkg::IdxW-1:0]  i_cfg_index,
    input  logic [bcc_pkg::CntW-1:0]  i_cfg_data
);

    bcc_pkg::t_cfg    cfg;
    bcc_pkg::t_result core_res;

    // Input register.
    logic r_in_valid;
    logic r_in_key;
    logic r_in_edge;

    // Result register.
    logic             r_out_valid;
    bcc_pkg::t_result r_out_res;

    logic advance;
    logic in_take;

    // Move the input item forward when the result register is free or drains now.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_key  <= s_axis_tdata[0];
            r_in_edge <= s_axis_tdata[1];
        end
    end

    // Hold the result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= core_res;
        end
    end

    bcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bcc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_key_pressed (r_in_key),
        .i_press_edge  (r_in_edge),
        .i_cfg         (cfg),
        .o_result      (core_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(bcc_pkg::ByteW - 3){1'b0}}, r_out_res.double_click,
                            r_out_res.long_press, r_out_res.short_click};

    `BCC_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, !s_axis_tready, r_in_valid && r_out_valid)
    `BCC_ASSERT_NEXT(a_step_loads, i_clk, i_rst_n, advance, r_out_valid)
    `BCC_ASSERT_NEXT(a_item_kept, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)

endmodule
